// ===== sv/swd_pkg.sv =====
// Shared types and constants of the serial wire debug bit sequencer.
package swd_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    localparam logic [2:0] ACK_OK   = 3'h4;
    localparam logic [2:0] ACK_WAIT = 3'h2;
    localparam int unsigned REQ_READ_BIT = 5;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_TICK,
        OP_LINE_RESET,
        OP_READ,
        OP_WRITE,
        OP_IGNORE
    } t_op;

    typedef enum logic [2:0] {
        FIN_NONE       = 3'd0,
        FIN_RESET_DONE = 3'd1,
        FIN_READ_DONE  = 3'd2,
        FIN_WRITE_DONE = 3'd3,
        FIN_READ_FAIL  = 3'd4
    } t_finish;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_ONES1,
        PH_RST_SEL,
        PH_RST_ONES2,
        PH_RST_ZEROS,
        PH_REQ,
        PH_TURN1,
        PH_ACK,
        PH_TURN_WAIT,
        PH_DATA_IN,
        PH_PARITY_IN,
        PH_TURN_POST,
        PH_TURN2,
        PH_DATA_OUT,
        PH_PARITY_OUT,
        PH_TRAIL
    } t_phase;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  request_byte;
        logic [31:0] write_word;
        logic [15:0] select_word;
        logic        line_sample;
    } t_cmd_item;

    typedef struct packed {
        t_op         op;
        logic [7:0]  request;
        logic [31:0] payload;
        logic        parity;
        logic        sample;
    } t_op_item;

    typedef struct packed {
        logic        clock_pulse;
        logic        line_level;
        logic        line_enable;
        logic        busy_res;
        logic [2:0]  finish_kind;
        logic [2:0]  ack_code;
        logic [31:0] read_word;
    } t_res_item;

endpackage

// ===== sv/swd_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface swd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/swd_front.sv =====
// Front end: takes command items and classifies them into operations.
module swd_front (
    swd_stream_if.sink   i_cmd,
    swd_stream_if.source o_op
);
    swd_pkg::t_op_item w_item;

    always_comb begin
        w_item.request = i_cmd.data.request_byte;
        w_item.sample  = i_cmd.data.line_sample;
        w_item.parity  = ^i_cmd.data.write_word;
        w_item.payload = i_cmd.data.write_word;
        w_item.op      = swd_pkg::OP_TICK;
        unique case (i_cmd.data.command)
            swd_pkg::CMD_TICK: begin
                w_item.op = swd_pkg::OP_TICK;
            end
            swd_pkg::CMD_RESET: begin
                w_item.op      = swd_pkg::OP_LINE_RESET;
                w_item.payload = {16'd0, i_cmd.data.select_word};
            end
            swd_pkg::CMD_READ: begin
                w_item.op = i_cmd.data.request_byte[swd_pkg::REQ_READ_BIT] ?
                            swd_pkg::OP_READ : swd_pkg::OP_IGNORE;
            end
            swd_pkg::CMD_WRITE: begin
                w_item.op = swd_pkg::OP_WRITE;
            end
        endcase
    end

    assign o_op.valid  = i_cmd.valid;
    assign o_op.data   = w_item;
    assign i_cmd.ready = o_op.ready;
endmodule

// ===== sv/swd_queue.sv =====
// Short queue of classified operations between the front end and the line engine.
module swd_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swd_stream_if.sink   i_push,
    swd_stream_if.source o_pop
);
    localparam int unsigned CW = swd_pkg::QUEUE_AW + 1;

    swd_pkg::t_op_item               r_mem [swd_pkg::QUEUE_DEPTH];
    logic [swd_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [swd_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [CW-1:0]                   r_count;
    logic                            w_push;
    logic                            w_pop;

    assign i_push.ready = (r_count != CW'(swd_pkg::QUEUE_DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.data   = r_mem[r_rd_ptr];
    assign w_push       = i_push.valid && i_push.ready;
    assign w_pop        = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            priority if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end
endmodule

// ===== sv/swd_engine.sv =====
// Line engine: runs the bit-period state machine and registers each result item.
module swd_engine #(
    parameter int unsigned RESET_ONES     = 53,
    parameter int unsigned TRAILING_ZEROS = 50,
    parameter int unsigned IDLE_ZEROS     = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swd_stream_if.sink   i_op,
    swd_stream_if.source o_res
);
    localparam logic [6:0] L_RST   = 7'(RESET_ONES);
    localparam logic [6:0] L_TRAIL = 7'(TRAILING_ZEROS);
    localparam logic [6:0] L_IDLE  = 7'(IDLE_ZEROS);

    swd_pkg::t_phase     r_phase, n_phase;
    logic [5:0]          r_bit, n_bit;
    logic [31:0]         r_shift, n_shift;
    logic [2:0]          r_ack, n_ack;
    logic [7:0]          r_req, n_req;
    logic [31:0]         r_pay, n_pay;
    logic                r_par, n_par;
    logic                r_wr, n_wr;
    logic                r_out_valid;
    swd_pkg::t_res_item  r_res, n_res;

    logic [6:0]          w_lim;
    logic [6:0]          w_inc;
    logic                w_done;
    logic                w_fire;
    logic [15:0]         w_sel;
    swd_pkg::t_op_item   w_it;
    swd_pkg::t_finish    w_fin;

    assign w_it        = i_op.data;
    assign i_op.ready  = !r_out_valid || o_res.ready;
    assign w_fire      = i_op.valid && i_op.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;
    assign w_sel       = r_pay[15:0];

    always_comb begin
        unique case (r_phase)
            swd_pkg::PH_RST_ONES1, swd_pkg::PH_RST_ONES2: w_lim = L_RST;
            swd_pkg::PH_RST_SEL:                          w_lim = 7'd16;
            swd_pkg::PH_RST_ZEROS:                        w_lim = L_IDLE;
            swd_pkg::PH_REQ:                              w_lim = 7'd8;
            swd_pkg::PH_ACK:                              w_lim = 7'd3;
            swd_pkg::PH_DATA_IN, swd_pkg::PH_DATA_OUT:    w_lim = 7'd32;
            swd_pkg::PH_TRAIL:                            w_lim = L_TRAIL;
            default:                                      w_lim = 7'd1;
        endcase
    end

    assign w_inc  = {1'b0, r_bit} + 7'd1;
    assign w_done = (w_inc >= w_lim);

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_ack   = r_ack;
        n_req   = r_req;
        n_pay   = r_pay;
        n_par   = r_par;
        n_wr    = r_wr;
        w_fin   = swd_pkg::FIN_NONE;
        n_res.clock_pulse = 1'b0;
        n_res.line_level  = 1'b0;
        n_res.line_enable = 1'b1;

        unique case (w_it.op)
            swd_pkg::OP_LINE_RESET, swd_pkg::OP_READ, swd_pkg::OP_WRITE: begin
                if (r_phase == swd_pkg::PH_IDLE) begin
                    n_bit = '0;
                    n_wr  = (w_it.op == swd_pkg::OP_WRITE);
                    if (w_it.op == swd_pkg::OP_LINE_RESET) begin
                        n_pay   = w_it.payload;
                        n_phase = swd_pkg::PH_RST_ONES1;
                    end else begin
                        n_req   = w_it.request;
                        n_pay   = w_it.payload;
                        n_par   = w_it.parity;
                        n_phase = swd_pkg::PH_REQ;
                    end
                end
            end
            swd_pkg::OP_IGNORE: begin
                n_phase = r_phase;
            end
            swd_pkg::OP_TICK: begin
                if (r_phase != swd_pkg::PH_IDLE) begin
                    n_res.clock_pulse = 1'b1;
                    n_bit = w_done ? 6'd0 : w_inc[5:0];
                    unique case (r_phase)
                        swd_pkg::PH_IDLE: begin
                            n_bit = r_bit;
                        end
                        swd_pkg::PH_RST_ONES1: begin
                            n_res.line_level = 1'b1;
                            if (w_done) n_phase = swd_pkg::PH_RST_SEL;
                        end
                        swd_pkg::PH_RST_SEL: begin
                            n_res.line_level = w_sel[~r_bit[3:0]];
                            if (w_done) n_phase = swd_pkg::PH_RST_ONES2;
                        end
                        swd_pkg::PH_RST_ONES2: begin
                            n_res.line_level = 1'b1;
                            if (w_done) n_phase = swd_pkg::PH_RST_ZEROS;
                        end
                        swd_pkg::PH_RST_ZEROS: begin
                            if (w_done) begin
                                n_phase = swd_pkg::PH_IDLE;
                                w_fin   = swd_pkg::FIN_RESET_DONE;
                            end
                        end
                        swd_pkg::PH_REQ: begin
                            n_res.line_level = r_req[~r_bit[2:0]];
                            if (w_done) n_phase = swd_pkg::PH_TURN1;
                        end
                        swd_pkg::PH_TURN1: begin
                            n_res.line_enable = 1'b0;
                            n_bit   = '0;
                            n_ack   = '0;
                            n_phase = swd_pkg::PH_ACK;
                        end
                        swd_pkg::PH_ACK: begin
                            n_res.line_enable = 1'b0;
                            n_ack = {r_ack[1:0], w_it.sample};
                            if (w_done) begin
                                priority if (r_wr) begin
                                    n_phase = swd_pkg::PH_TURN2;
                                end else if (n_ack == swd_pkg::ACK_WAIT) begin
                                    n_phase = swd_pkg::PH_TURN_WAIT;
                                end else if (n_ack == swd_pkg::ACK_OK) begin
                                    n_phase = swd_pkg::PH_DATA_IN;
                                end else begin
                                    n_phase = swd_pkg::PH_IDLE;
                                    w_fin   = swd_pkg::FIN_READ_FAIL;
                                end
                            end
                        end
                        swd_pkg::PH_TURN_WAIT: begin
                            n_res.line_enable = 1'b0;
                            n_bit   = '0;
                            n_phase = swd_pkg::PH_REQ;
                        end
                        swd_pkg::PH_DATA_IN: begin
                            n_res.line_enable = 1'b0;
                            n_shift = {r_shift[30:0], w_it.sample};
                            if (w_done) n_phase = swd_pkg::PH_PARITY_IN;
                        end
                        swd_pkg::PH_PARITY_IN: begin
                            n_res.line_enable = 1'b0;
                            n_bit   = r_bit;
                            n_phase = swd_pkg::PH_TURN_POST;
                        end
                        swd_pkg::PH_TURN_POST: begin
                            n_res.line_enable = 1'b0;
                            n_bit   = '0;
                            n_phase = swd_pkg::PH_TRAIL;
                        end
                        swd_pkg::PH_TURN2: begin
                            n_res.line_enable = 1'b0;
                            n_bit   = '0;
                            n_phase = swd_pkg::PH_DATA_OUT;
                        end
                        swd_pkg::PH_DATA_OUT: begin
                            n_res.line_level = r_pay[~r_bit[4:0]];
                            if (w_done) n_phase = swd_pkg::PH_PARITY_OUT;
                        end
                        swd_pkg::PH_PARITY_OUT: begin
                            n_res.line_level = r_par;
                            n_bit   = '0;
                            n_phase = swd_pkg::PH_TRAIL;
                        end
                        swd_pkg::PH_TRAIL: begin
                            if (w_done) begin
                                n_phase = swd_pkg::PH_IDLE;
                                w_fin   = r_wr ? swd_pkg::FIN_WRITE_DONE
                                               : swd_pkg::FIN_READ_DONE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        n_res.busy_res    = (n_phase != swd_pkg::PH_IDLE);
        n_res.finish_kind = w_fin;
        n_res.ack_code    = n_ack;
        n_res.read_word   = n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= swd_pkg::PH_IDLE;
            r_bit       <= '0;
            r_shift     <= '0;
            r_ack       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_ack       <= n_ack;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_req <= n_req;
            r_pay <= n_pay;
            r_par <= n_par;
            r_wr  <= n_wr;
            r_res <= n_res;
        end
    end

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == swd_pkg::PH_IDLE |-> r_bit == '0)
        else $error("Bit counter is not cleared while idle.");

    a_finish_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.finish_kind != swd_pkg::FIN_NONE
        |-> !r_res.busy_res && r_res.clock_pulse)
        else $error("Finish reported on an item that leaves the engine busy.");

    a_release_clocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.line_enable |-> r_res.clock_pulse && !r_res.line_level)
        else $error("Line released outside a clocked bit period.");

    a_idle_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_phase == swd_pkg::PH_IDLE |=> !r_res.clock_pulse)
        else $error("Clock pulse issued while idle.");
endmodule

// ===== sv/swd_master_bit_sequencer.sv =====
// Top level of the serial wire debug master bit sequencer.
// Every command item yields exactly one result item. A start item loads a line
// reset, read or write; each later tick item is one serial bit period. The
// block takes one item per clock while the queue has room: a front end
// classifies items into a four-entry queue, and the line engine executes one
// item per cycle, while its output register is free or being taken, into
// that register, which holds the result of an item until it is taken.
// While a result waits to be taken, up to four more items are still accepted
// into the queue before the input stalls.
module swd_master_bit_sequencer #(
    parameter int unsigned RESET_ONES     = 53,
    parameter int unsigned TRAILING_ZEROS = 50,
    parameter int unsigned IDLE_ZEROS     = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swd_stream_if.sink   i_cmd,
    swd_stream_if.source o_res
);
    swd_stream_if #(.T(swd_pkg::t_op_item)) w_push ();
    swd_stream_if #(.T(swd_pkg::t_op_item)) w_pop ();

    swd_front u_front (
        .i_cmd (i_cmd),
        .o_op  (w_push)
    );

    swd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_pop   (w_pop)
    );

    swd_engine #(
        .RESET_ONES     (RESET_ONES),
        .TRAILING_ZEROS (TRAILING_ZEROS),
        .IDLE_ZEROS     (IDLE_ZEROS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_pop),
        .o_res   (o_res)
    );
endmodule
